/* hw/rtl/dual_pcg_lcg_random_generator_macros.svh */
// Assertion macros for the dual PCG random generator.
`ifndef DUAL_PCG_LCG_RANDOM_GENERATOR_MACROS_SVH
`define DUAL_PCG_LCG_RANDOM_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define DPLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dplr: assertion failed");
// next-cycle implication
`define DPLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dplr: assertion failed");
`else
`define DPLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DPLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/dplr_pkg.sv */
// Shared types, constants and the output mix function of the dual PCG generator.
package dplr_pkg;

    // LCG multiplier, split into 32-bit halves for the shared multiplier
    localparam logic [63:0] LCG_MULT    = 64'd6364136223846793005;
    localparam logic [31:0] LCG_MULT_LO = LCG_MULT[31:0];
    localparam logic [31:0] LCG_MULT_HI = LCG_MULT[63:32];

    // seeding words: seed1 lo, seed1 hi, seq1, seed2 lo, seed2 hi, seq2
    localparam int unsigned WORD_CNT = 6;
    localparam int unsigned WIDX_W   = $clog2(WORD_CNT);
    localparam logic [WIDX_W-1:0] LAST_SEED_WORD = WIDX_W'(WORD_CNT - 1);
    localparam logic [WIDX_W-1:0] LAST_DRAW_WORD = WIDX_W'(1);

    // word slots used by the reseed procedure
    localparam int unsigned W_S1_LO = 0;
    localparam int unsigned W_S1_HI = 1;
    localparam int unsigned W_SEQ1  = 2;
    localparam int unsigned W_S2_LO = 3;
    localparam int unsigned W_S2_HI = 4;
    localparam int unsigned W_SEQ2  = 5;
    // bits of the stream selectors compared for a collision
    localparam int unsigned SEQ_CMP_W = 31;

    // item kinds on the input tuser
    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_SEED,
        LD_ONE,
        LD_TWO
    } t_load;

    typedef enum logic [1:0] {
        SV_NONE,
        SV_ONE,
        SV_TWO
    } t_save;

    typedef enum logic [2:0] {
        MP_IDLE,
        MP_P0,
        MP_P1,
        MP_P2,
        MP_P3
    } t_mphase;

    // controller to datapath commands
    typedef struct packed {
        t_load             load;
        t_mphase           mphase;
        logic              cap;
        logic [WIDX_W-1:0] idx;
        t_save             save;
        logic              commit;
        logic              out_load;
        logic              out_draw;
    } t_dp_cmd;

    // PCG XSH-RR: xorshift high bits, then rotate right by the top five bits
    function automatic logic [31:0] pcg_mix(input logic [63:0] x);
        logic [63:0] xx;
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [63:0] dbl;
        xx  = x ^ (x >> 18);
        xs  = xx[58:27];
        rot = x[63:59];
        dbl = {xs, xs} >> rot;
        return dbl[31:0];
    endfunction

endpackage

/* hw/rtl/dplr_ctrl.sv */
// Sequencing state machine of the dual PCG generator.
module dplr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_draw,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output dplr_pkg::t_dp_cmd o_cmd
);
    import dplr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_POST,
        ST_COMMIT,
        ST_FIN
    } t_state;

    t_state            r_state;
    logic              r_op_draw;
    logic [WIDX_W-1:0] r_idx;
    logic              r_out_valid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = LD_NONE;
        o_cmd.mphase   = MP_IDLE;
        o_cmd.save     = SV_NONE;
        o_cmd.idx      = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = (i_in_draw == OP_DRAW) ? LD_ONE : LD_SEED;
                end
            end
            ST_P0: o_cmd.mphase = MP_P0;
            ST_P1: o_cmd.mphase = MP_P1;
            ST_P2: o_cmd.mphase = MP_P2;
            ST_P3: o_cmd.mphase = MP_P3;
            ST_POST: begin
                o_cmd.cap = 1'b1;
                if (r_op_draw) begin
                    if (r_idx == '0) begin
                        o_cmd.save = SV_ONE;
                        o_cmd.load = LD_TWO;
                    end else begin
                        o_cmd.save = SV_TWO;
                    end
                end
            end
            ST_COMMIT: o_cmd.commit = 1'b1;
            ST_FIN: begin
                o_cmd.out_load = !r_out_valid || i_out_ready;
                o_cmd.out_draw = r_op_draw;
            end
            default: ;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op_draw   <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result register: load a finished item, or drain on ready
            if (r_state == ST_FIN && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op_draw <= (i_in_draw == OP_DRAW);
                        r_idx     <= '0;
                        r_state   <= ST_P0;
                    end
                end
                ST_P0: r_state <= ST_P1;
                ST_P1: r_state <= ST_P2;
                ST_P2: r_state <= ST_P3;
                ST_P3: r_state <= ST_POST;
                ST_POST: begin
                    if (r_op_draw && r_idx == LAST_DRAW_WORD) begin
                        r_state <= ST_FIN;
                    end else if (!r_op_draw && r_idx == LAST_SEED_WORD) begin
                        r_state <= ST_COMMIT;
                    end else begin
                        r_idx   <= r_idx + WIDX_W'(1);
                        r_state <= ST_P0;
                    end
                end
                ST_COMMIT: r_state <= ST_FIN;
                ST_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/dplr_dpath.sv */
// Datapath: generator state, shared 32x32 multiplier, mix and result register.
module dplr_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dplr_pkg::t_dp_cmd i_cmd,
    input  logic [63:0]       i_seed,
    output logic [63:0]       o_value
);
    import dplr_pkg::*;

    // architectural generator state; increments kept as q with implied low one
    logic [63:0] r_s1, r_s2;
    logic [31:0] r_q1, r_q2;

    // working step registers
    logic [63:0] r_x;
    logic [32:0] r_c;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [31:0] r_word [WORD_CNT];
    logic [63:0] r_value;

    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_prod;
    logic [31:0] w_mix;
    logic [31:0] w_q2;

    // shared multiplier: lo*lo, hi*lo, lo*hi in phases P0, P1 and P2
    assign w_mul_a = (i_cmd.mphase == MP_P1) ? r_x[63:32] : r_x[31:0];
    assign w_mul_b = (i_cmd.mphase == MP_P2) ? LCG_MULT_HI : LCG_MULT_LO;
    assign w_prod  = {32'b0, w_mul_a} * {32'b0, w_mul_b};

    assign w_mix = pcg_mix(r_x);

    // second stream is flipped when its selector collides with the first
    assign w_q2 = (r_word[W_SEQ1][SEQ_CMP_W-1:0] == r_word[W_SEQ2][SEQ_CMP_W-1:0])
                  ? ~r_word[W_SEQ2] : r_word[W_SEQ2];

    assign o_value = r_value;

    // step arithmetic and word capture
    always_ff @(posedge i_clk) begin
        case (i_cmd.mphase)
            MP_P0: r_prod <= w_prod;
            MP_P1: begin
                r_prod <= w_prod;
                r_acc  <= r_prod + {31'b0, r_c};
            end
            MP_P2: begin
                r_prod <= w_prod;
                r_acc  <= r_acc + {r_prod[31:0], 32'b0};
            end
            default: ;
        endcase

        case (i_cmd.load)
            LD_SEED: begin
                r_x <= i_seed;
                r_c <= 33'd1;
            end
            LD_ONE: begin
                r_x <= r_s1;
                r_c <= {r_q1, 1'b1};
            end
            LD_TWO: begin
                r_x <= r_s2;
                r_c <= {r_q2, 1'b1};
            end
            default: begin
                if (i_cmd.mphase == MP_P3) begin
                    r_x <= r_acc + {r_prod[31:0], 32'b0};
                end
            end
        endcase

        if (i_cmd.cap) begin
            r_word[i_cmd.idx] <= w_mix;
        end

        if (i_cmd.out_load) begin
            r_value <= i_cmd.out_draw ? {r_word[0], r_word[1]} : 64'd0;
        end
    end

    // generator state with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_q1 <= '0;
            r_q2 <= '0;
        end else begin
            if (i_cmd.save == SV_ONE) begin
                r_s1 <= r_x;
            end
            if (i_cmd.save == SV_TWO) begin
                r_s2 <= r_x;
            end
            if (i_cmd.commit) begin
                r_s1 <= {r_word[W_S1_HI], r_word[W_S1_LO]};
                r_q1 <= r_word[W_SEQ1];
                r_s2 <= {r_word[W_S2_HI], r_word[W_S2_LO]};
                r_q2 <= w_q2;
            end
        end
    end

endmodule

/* hw/rtl/dual_pcg_lcg_random_generator.sv */
// Top level of the dual-stream PCG random generator.
//
//  channel   dir  tdata              tuser           meaning
//  s_axis    in   seed[63:0]         op[0]           0 = reseed, 1 = draw
//  m_axis    out  value[63:0]        -               draw value, zero after reseed
//
// Each LCG step runs phases P0 to P3 on one shared 32x32 multiplier, then
// a POST state to mix and store. A reseed runs six helper steps and a
// commit. New items are taken only when the block is idle.
// The result register frees the input side; a stalled output holds the
// next finished item in the last state. Reset is synchronous, active low.
`include "dual_pcg_lcg_random_generator_macros.svh"

module dual_pcg_lcg_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] seed
    input  logic [0:0]  s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] value
);
    import dplr_pkg::*;

    t_dp_cmd w_cmd;

    // sequencer
    dplr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_draw   (s_axis_tuser[0]),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // arithmetic and state
    dplr_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_seed  (s_axis_tdata),
        .o_value (m_axis_tdata)
    );

    // checks
    `DPLR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `DPLR_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid)
    `DPLR_ASSERT_NEXT(a_reseed_gives_zero, i_clk, i_rst_n, w_cmd.out_load && !w_cmd.out_draw, m_axis_tvalid && (m_axis_tdata == 64'd0))

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the dual-stream PCG random generator.
//
// Items go in on the s_axis side as reseed or draw commands. For every
// accepted item a local model of the two LCG streams works out the 64-bit
// result. Results that leave on the m_axis side are checked in order against
// those predictions. The run has a short directed part taken from a table,
// then random traffic. Both sides of the block get random gaps and stalls,
// and once the output is held off long enough to back up the input.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dplr_pkg::*;

    localparam int RANDOM_ITEMS = 580;
    localparam int HOLD_AT      = 100;   // results seen before the long hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    // one row of directed stimulus
    typedef struct {
        logic        op;
        logic [63:0] seed;
        bit          typed;      // value below is used instead of the model
        logic [63:0] value;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [63:0] seed
    logic [0:0]  s_axis_tuser;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [63:0] value

    // model state: index 0 is generator one, index 1 generator two
    logic [63:0] stream_state [2];
    logic [32:0] stream_inc   [2];

    logic [63:0] pending_values[$];
    t_stim_row   stim_table[$];
    int          mismatch_count;
    int          results_seen;

    dual_pcg_lcg_random_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // XSH-RR output permutation of one LCG state
    function automatic logic [31:0] xsh_rr(input logic [63:0] x);
        logic [63:0] folded;
        logic [31:0] xs;
        int unsigned r;
        folded = (x >> 18) ^ x;
        xs     = folded[58:27];
        r      = x[63:59];
        return (xs >> r) | (xs << ((32 - r) & 31));
    endfunction

    // state and increments that a seed produces, via the increment-1 helper
    function automatic void derive_streams(input logic [63:0] seed,
                                           output logic [63:0] s1,
                                           output logic [32:0] inc1,
                                           output logic [63:0] s2,
                                           output logic [32:0] inc2);
        logic [63:0] h;
        logic [31:0] w [6];
        h = seed;
        for (int k = 0; k < 6; k++) begin
            h    = h * LCG_MULT + 64'd1;
            w[k] = xsh_rr(h);
        end
        // streams too alike: flip the second selector
        if (w[2][30:0] == w[5][30:0])
            w[5] = ~w[5];
        s1   = {w[1], w[0]};
        inc1 = {w[2], 1'b1};
        s2   = {w[4], w[3]};
        inc2 = {w[5], 1'b1};
    endfunction

    // apply one item to the model and return the value the block should give
    function automatic logic [63:0] next_value(input logic op, input logic [63:0] seed);
        logic [31:0] half [2];
        if (op == OP_RESEED) begin
            derive_streams(seed, stream_state[0], stream_inc[0],
                           stream_state[1], stream_inc[1]);
            return 64'd0;
        end
        for (int g = 0; g < 2; g++) begin
            stream_state[g] = stream_state[g] * LCG_MULT + {31'd0, stream_inc[g]};
            half[g]         = xsh_rr(stream_state[g]);
        end
        return {half[0], half[1]};
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 19)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // offer one item after a gap, wait for acceptance, record the expectation
    task automatic offer_item(input logic op, input logic [63:0] seed,
                              input bit typed, input logic [63:0] typed_value,
                              input int gap);
        logic [63:0] predicted;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= seed;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predicted = next_value(op, seed);
        pending_values.push_back(typed ? typed_value : predicted);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("testbench failed");
        $finish;
    end

    // output side: random stalls, calm stretches, one long hold-off
    initial begin
        int stall_left;
        int cycle_cnt;
        bit hold_done;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        cycle_cnt     = 0;
        hold_done     = 0;
        forever begin
            @(negedge i_clk);
            cycle_cnt++;
            if (!hold_done && results_seen >= HOLD_AT) begin
                m_axis_tready <= 1'b0;
                hold_done = 1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                // every third stretch of cycles runs without stalls
                if ((cycle_cnt / 256) % 3 != 0 && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // result checker
    initial begin
        logic [63:0] want;
        mismatch_count = 0;
        results_seen   = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (pending_values.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, m_axis_tdata);
                end else begin
                    want = pending_values.pop_front();
                    if (m_axis_tdata !== want) begin
                        mismatch_count++;
                        $display("%0t: value mismatch, expected %h, got %h",
                                 $time, want, m_axis_tdata);
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [63:0] rot_seed;
        logic [63:0] s1, s2, seed;
        logic [32:0] inc1, inc2;
        logic        op;
        int          tries;
        int          wait_cnt;

        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = OP_DRAW;
        i_rst_n         = 1'b0;
        stream_state[0] = '0;
        stream_state[1] = '0;
        stream_inc[0]   = 33'd1;
        stream_inc[1]   = 33'd1;

        // find a seed whose first draw rotates generator one by zero
        rot_seed = 64'd1;
        tries    = 0;
        do begin
            rot_seed = {$urandom, $urandom};
            derive_streams(rot_seed, s1, inc1, s2, inc2);
            s1 = s1 * LCG_MULT + {31'd0, inc1};
            tries++;
        end while (s1[63:59] != 5'd0 && tries < 10000);

        // directed rows; the very first draw runs from the reset state
        stim_table.push_back('{OP_DRAW,   64'd0,                 1'b1, 64'd0});
        stim_table.push_back('{OP_DRAW,   64'd0,                 1'b0, 64'd0});
        stim_table.push_back('{OP_DRAW,   '1,                    1'b0, 64'd0});
        stim_table.push_back('{OP_RESEED, 64'd0,                 1'b1, 64'd0});
        stim_table.push_back('{OP_DRAW,   64'd0,                 1'b0, 64'd0});
        stim_table.push_back('{OP_DRAW,   64'd0,                 1'b0, 64'd0});
        stim_table.push_back('{OP_RESEED, '1,                    1'b1, 64'd0});
        stim_table.push_back('{OP_DRAW,   64'd0,                 1'b0, 64'd0});
        stim_table.push_back('{OP_RESEED, 64'h8000_0000_0000_0000, 1'b1, 64'd0});
        stim_table.push_back('{OP_DRAW,   64'd0,                 1'b0, 64'd0});
        stim_table.push_back('{OP_RESEED, 64'd1,                 1'b1, 64'd0});
        stim_table.push_back('{OP_DRAW,   64'd0,                 1'b0, 64'd0});
        stim_table.push_back('{OP_DRAW,   64'd0,                 1'b0, 64'd0});
        stim_table.push_back('{OP_RESEED, 64'h5555_5555_5555_5555, 1'b1, 64'd0});
        stim_table.push_back('{OP_DRAW,   64'h5555_5555_5555_5555, 1'b0, 64'd0});
        stim_table.push_back('{OP_RESEED, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'd0});
        stim_table.push_back('{OP_DRAW,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0});
        stim_table.push_back('{OP_RESEED, rot_seed,              1'b1, 64'd0});
        stim_table.push_back('{OP_DRAW,   64'd0,                 1'b0, 64'd0});
        stim_table.push_back('{OP_DRAW,   64'd0,                 1'b0, 64'd0});

        // reset
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i])
            offer_item(stim_table[i].op, stim_table[i].seed, stim_table[i].typed,
                       stim_table[i].value, idle_len());

        // random traffic: mostly draws, now and then a reseed
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            op   = ($urandom_range(0, 7) == 0) ? OP_RESEED : OP_DRAW;
            seed = {$urandom, $urandom};
            if (op == OP_RESEED && $urandom_range(0, 9) == 0)
                seed = $urandom_range(0, 1) ? '1 : '0;
            // every fourth block of 40 items is sent back to back
            offer_item(op, seed, 1'b0, 64'd0, ((n / 40) % 4 == 0) ? 0 : idle_len());
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // drain, then give stray results time to show up
        while (pending_values.size() != 0)
            @(posedge i_clk);
        wait_cnt = 0;
        while (wait_cnt < DRAIN_CYCLES) begin
            @(posedge i_clk);
            wait_cnt++;
        end

        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dplr_pkg.sv
hw/rtl/dplr_ctrl.sv
hw/rtl/dplr_dpath.sv
hw/rtl/dual_pcg_lcg_random_generator.sv
tb/sv/testbench.sv
